FILE: hdl/spam_pkg.sv
package spam_pkg;
    localparam int MAX_TERMS = 8;
    localparam int COEF_BITS = 16;
    localparam int EXP_BITS  = 10;
    localparam int IDX_W     = 3;
    localparam int CNT_W     = 4;
    localparam int OEXP_W    = 11;
    localparam int ACC_W     = 40;
    localparam int K_W       = 2 * IDX_W;

    typedef enum logic [1:0] {
        REQ_LOAD_A = 2'd0,
        REQ_LOAD_B = 2'd1,
        REQ_MUL    = 2'd2,
        REQ_ADD    = 2'd3
    } req_t;
endpackage

FILE: hdl/sparse_polynomial_add_multiply.sv
// Loads two sparse polynomials term by term and emits their product or sum in
// falling exponent order. A product or sum request finds each result term by
// one pass of a shared multiply and compare unit, over all stored term pairs
// for a product and over each stored term of both operands for a sum, followed
// by a pipeline drain and a decision state, and there is one pass more than
// there are distinct exponents; the output register then holds each term until
// it is taken. Input is not accepted during an emit request.
module sparse_polynomial_add_multiply (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_req_type,
    input  logic                               s_first_term,
    input  logic signed [spam_pkg::COEF_BITS-1:0] s_coef_in,
    input  logic [spam_pkg::EXP_BITS-1:0]      s_exp_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [spam_pkg::ACC_W-1:0]  m_coef_out,
    output logic [spam_pkg::OEXP_W-1:0]        m_exp_out,
    output logic                               m_last_term,
    output logic                               m_overflow
);
    import spam_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_WALK, ST_DRAIN, ST_DECIDE, ST_OUT
    } state_t;

    state_t state_reg;
    logic signed [COEF_BITS-1:0] a_coef_reg [MAX_TERMS];
    logic [EXP_BITS-1:0]         a_exp_reg  [MAX_TERMS];
    logic signed [COEF_BITS-1:0] b_coef_reg [MAX_TERMS];
    logic [EXP_BITS-1:0]         b_exp_reg  [MAX_TERMS];
    logic [CNT_W-1:0] a_count_reg, b_count_reg;
    logic dropped_reg, mul_reg, final_reg;
    logic [K_W-1:0] k_reg;
    logic t_valid_reg;
    logic [OEXP_W-1:0] t_exp_reg;
    logic signed [ACC_W-1:0] t_coef_reg;
    logic [OEXP_W:0] bound_reg;
    logic found_reg;
    logic [OEXP_W-1:0] best_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic pend_reg;
    logic [OEXP_W-1:0] pend_exp_reg;
    logic signed [ACC_W-1:0] pend_coef_reg;

    logic [IDX_W-1:0] ai, bi;
    logic t_valid_next;
    logic [OEXP_W-1:0] t_exp_next;
    logic signed [ACC_W-1:0] t_coef_next;
    logic signed [2*COEF_BITS-1:0] prod;
    logic k_end;
    logic cand;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        ai = mul_reg ? k_reg[K_W-1:IDX_W] : k_reg[IDX_W-1:0];
        bi = k_reg[IDX_W-1:0];
        prod = a_coef_reg[ai] * b_coef_reg[bi];
        if (mul_reg) begin
            t_valid_next = ({1'b0, ai} < a_count_reg) && ({1'b0, bi} < b_count_reg);
            t_exp_next   = OEXP_W'(a_exp_reg[ai]) + OEXP_W'(b_exp_reg[bi]);
            t_coef_next  = ACC_W'(prod);
            k_end        = (k_reg == {K_W{1'b1}});
        end else if (!k_reg[IDX_W]) begin
            t_valid_next = ({1'b0, ai} < a_count_reg);
            t_exp_next   = OEXP_W'(a_exp_reg[ai]);
            t_coef_next  = ACC_W'(a_coef_reg[ai]);
            k_end        = 1'b0;
        end else begin
            t_valid_next = ({1'b0, bi} < b_count_reg);
            t_exp_next   = OEXP_W'(b_exp_reg[bi]);
            t_coef_next  = ACC_W'(b_coef_reg[bi]);
            k_end        = (k_reg[IDX_W:0] == {(IDX_W+1){1'b1}});
        end
        cand = t_valid_reg && ({1'b0, t_exp_reg} < bound_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            a_count_reg <= '0;
            b_count_reg <= '0;
            dropped_reg <= 1'b0;
            t_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            final_reg   <= 1'b0;
        end else begin
            if ((state_reg == ST_WALK || state_reg == ST_DRAIN) && cand) begin
                if (!found_reg || t_exp_reg > best_reg) begin
                    best_reg  <= t_exp_reg;
                    acc_reg   <= t_coef_reg;
                    found_reg <= 1'b1;
                end else if (t_exp_reg == best_reg) begin
                    acc_reg <= acc_reg + t_coef_reg;
                end
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        unique case (req_t'(s_req_type))
                            REQ_LOAD_A: begin
                                if (s_first_term || a_count_reg < CNT_W'(MAX_TERMS)) begin
                                    a_coef_reg[s_first_term ? '0 : a_count_reg[IDX_W-1:0]]
                                        <= s_coef_in;
                                    a_exp_reg[s_first_term ? '0 : a_count_reg[IDX_W-1:0]]
                                        <= s_exp_in;
                                    a_count_reg <= s_first_term ? CNT_W'(1)
                                                                : a_count_reg + 1'b1;
                                end else begin
                                    dropped_reg <= 1'b1;
                                end
                            end
                            REQ_LOAD_B: begin
                                if (s_first_term || b_count_reg < CNT_W'(MAX_TERMS)) begin
                                    b_coef_reg[s_first_term ? '0 : b_count_reg[IDX_W-1:0]]
                                        <= s_coef_in;
                                    b_exp_reg[s_first_term ? '0 : b_count_reg[IDX_W-1:0]]
                                        <= s_exp_in;
                                    b_count_reg <= s_first_term ? CNT_W'(1)
                                                                : b_count_reg + 1'b1;
                                end else begin
                                    dropped_reg <= 1'b1;
                                end
                            end
                            default: begin
                                mul_reg     <= (s_req_type == REQ_MUL);
                                bound_reg   <= {1'b1, {OEXP_W{1'b0}}};
                                k_reg       <= '0;
                                found_reg   <= 1'b0;
                                pend_reg    <= 1'b0;
                                t_valid_reg <= 1'b0;
                                state_reg   <= ST_WALK;
                            end
                        endcase
                    end
                end
                ST_WALK: begin
                    t_valid_reg <= t_valid_next;
                    t_exp_reg   <= t_exp_next;
                    t_coef_reg  <= t_coef_next;
                    k_reg       <= k_reg + 1'b1;
                    if (k_end) state_reg <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    t_valid_reg <= 1'b0;
                    state_reg   <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    k_reg     <= '0;
                    found_reg <= 1'b0;
                    m_overflow <= dropped_reg;
                    if (found_reg) begin
                        bound_reg <= {1'b0, best_reg};
                        if (acc_reg != '0) begin
                            pend_reg      <= 1'b1;
                            pend_exp_reg  <= best_reg;
                            pend_coef_reg <= acc_reg;
                            if (pend_reg) begin
                                m_coef_out  <= pend_coef_reg;
                                m_exp_out   <= pend_exp_reg;
                                m_last_term <= 1'b0;
                                final_reg   <= 1'b0;
                                state_reg   <= ST_OUT;
                            end else begin
                                state_reg <= ST_WALK;
                            end
                        end else begin
                            state_reg <= ST_WALK;
                        end
                    end else begin
                        m_coef_out  <= pend_reg ? pend_coef_reg : '0;
                        m_exp_out   <= pend_reg ? pend_exp_reg : '0;
                        m_last_term <= 1'b1;
                        final_reg   <= 1'b1;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= final_reg ? ST_IDLE : ST_WALK;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import spam_pkg::*;

    typedef struct packed {
        logic signed [ACC_W-1:0] coef;
        logic [OEXP_W-1:0]       exp;
        logic                    last;
        logic                    ovf;
    } term_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [1:0]                  s_req_type;
    logic                        s_first_term;
    logic signed [COEF_BITS-1:0] s_coef_in;
    logic [EXP_BITS-1:0]         s_exp_in;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [ACC_W-1:0]     m_coef_out;
    logic [OEXP_W-1:0]           m_exp_out;
    logic                        m_last_term;
    logic                        m_overflow;

    sparse_polynomial_add_multiply DUT (.*);

    term_t pending_terms[$];
    int    mismatches = 0;
    bit    steady = 0;

    logic signed [COEF_BITS-1:0] poly_a_coef[MAX_TERMS], poly_b_coef[MAX_TERMS];
    logic [EXP_BITS-1:0]         poly_a_exp[MAX_TERMS], poly_b_exp[MAX_TERMS];
    int                          a_terms = 0, b_terms = 0;
    bit                          term_dropped = 0;
    longint                      merged[2048];

    initial begin
        aclk = 0;
        forever begin
            #2 aclk = 1;
            #2 aclk = 0;
        end
    end

    initial begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    always @(negedge aclk) m_ready <= steady || ($urandom_range(99) >= 36);

    // Updates the model for a load request, or works out the result terms of a product or sum request and queues them.
    function automatic void predict_request(req_t req, bit first,
                                            logic signed [COEF_BITS-1:0] c,
                                            logic [EXP_BITS-1:0] e);
        int    found;
        term_t t;
        if (req == REQ_LOAD_A || req == REQ_LOAD_B) begin
            if (req == REQ_LOAD_A) begin
                if (first) a_terms = 0;
                if (a_terms >= MAX_TERMS) term_dropped = 1;
                else begin
                    poly_a_coef[a_terms] = c;
                    poly_a_exp[a_terms] = e;
                    a_terms++;
                end
            end else begin
                if (first) b_terms = 0;
                if (b_terms >= MAX_TERMS) term_dropped = 1;
                else begin
                    poly_b_coef[b_terms] = c;
                    poly_b_exp[b_terms] = e;
                    b_terms++;
                end
            end
            return;
        end
        foreach (merged[k]) merged[k] = 0;
        if (req == REQ_MUL) begin
            for (int i = 0; i < a_terms; i++)
                for (int j = 0; j < b_terms; j++)
                    merged[int'(poly_a_exp[i]) + int'(poly_b_exp[j])] +=
                        longint'(poly_a_coef[i]) * longint'(poly_b_coef[j]);
        end else begin
            for (int i = 0; i < a_terms; i++)
                merged[poly_a_exp[i]] += longint'(poly_a_coef[i]);
            for (int j = 0; j < b_terms; j++)
                merged[poly_b_exp[j]] += longint'(poly_b_coef[j]);
        end
        found = 0;
        for (int k = 2047; k >= 0; k--) begin
            if (merged[k][ACC_W-1:0] != 0) begin
                t.coef = merged[k][ACC_W-1:0];
                t.exp = OEXP_W'(k);
                t.last = 0;
                t.ovf = term_dropped;
                pending_terms = {pending_terms, t};
                found++;
            end
        end
        if (found == 0) begin
            t = '0;
            t.last = 1;
            t.ovf = term_dropped;
            pending_terms = {pending_terms, t};
        end else begin
            pending_terms[pending_terms.size()-1].last = 1;
        end
    endfunction

    always @(posedge aclk) begin
        term_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_terms.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected term coef=%0d exp=%0d", m_coef_out, m_exp_out);
            end else begin
                want = pending_terms.pop_front();
                if (m_coef_out !== want.coef || m_exp_out !== want.exp ||
                    m_last_term !== want.last || m_overflow !== want.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("term mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                 want.coef, want.exp, want.last, want.ovf,
                                 m_coef_out, m_exp_out, m_last_term, m_overflow);
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(req_t req, bit first, logic signed [COEF_BITS-1:0] c,
                                logic [EXP_BITS-1:0] e);
        if (!steady) begin
            while ($urandom_range(99) < 36) begin
                s_valid <= 0;
                @(negedge aclk);
            end
        end
        s_valid <= 1;
        s_req_type <= req;
        s_first_term <= first;
        s_coef_in <= c;
        s_exp_in <= e;
        predict_request(req, first, c, e);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 0;
        while (pending_terms.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic load_poly(req_t which, int n, bit small_coefs);
        int prev, e;
        logic signed [COEF_BITS-1:0] c;
        prev = 1024;
        for (int k = 0; k < n; k++) begin
            e = $urandom_range(prev - 1, (n > MAX_TERMS ? 0 : n - 1 - k));
            if (e >= prev) e = prev - 1;
            if (e < 0) e = $urandom_range(1023);
            prev = (e > 0) ? e : 1;
            c = small_coefs ? $signed(COEF_BITS'($urandom_range(7)) - COEF_BITS'(3))
                            : COEF_BITS'($urandom);
            send_request(which, k == 0, c, EXP_BITS'(e));
        end
    endtask

    task automatic test_empty();
        send_request(REQ_MUL, 1'b0, '0, '0);
        send_request(REQ_ADD, 1'b1, COEF_BITS'(-1), EXP_BITS'(1023));
        load_poly(REQ_LOAD_A, 2, 1'b0);
        send_request(REQ_MUL, 1'b0, '0, '0);
        send_request(REQ_ADD, 1'b0, '0, '0);
    endtask

    task automatic test_extremes();
        send_request(REQ_LOAD_A, 1'b1, COEF_BITS'(-32768), EXP_BITS'(1023));
        send_request(REQ_LOAD_A, 1'b0, COEF_BITS'(32767), '0);
        send_request(REQ_LOAD_B, 1'b1, COEF_BITS'(-32768), EXP_BITS'(1023));
        send_request(REQ_LOAD_B, 1'b0, COEF_BITS'(-32768), '0);
        send_request(REQ_MUL, 1'b0, '0, '0);
        send_request(REQ_ADD, 1'b0, '0, '0);
    endtask

    task automatic test_cancel_and_order();
        send_request(REQ_LOAD_A, 1'b1, COEF_BITS'(5), EXP_BITS'(3));
        send_request(REQ_LOAD_A, 1'b0, COEF_BITS'(7), EXP_BITS'(9));
        send_request(REQ_LOAD_A, 1'b0, COEF_BITS'(2), EXP_BITS'(3));
        send_request(REQ_LOAD_B, 1'b1, COEF_BITS'(-7), EXP_BITS'(9));
        send_request(REQ_LOAD_B, 1'b0, COEF_BITS'(-7), EXP_BITS'(3));
        send_request(REQ_ADD, 1'b0, '0, '0);
        send_request(REQ_MUL, 1'b0, '0, '0);
    endtask

    task automatic test_full();
        drain_results();
        load_poly(REQ_LOAD_A, MAX_TERMS + 1, 1'b0);
        load_poly(REQ_LOAD_B, MAX_TERMS, 1'b0);
        send_request(REQ_MUL, 1'b0, '0, '0);
    endtask

    task automatic test_random(int items);
        int sent;
        sent = 0;
        while (sent < items) begin
            if (sent > items / 3 && sent < items / 2) steady = 1;
            else steady = 0;
            case ($urandom_range(9))
                0: begin
                    send_request(req_t'($urandom_range(3)), 1'($urandom_range(1)),
                                 COEF_BITS'($urandom), EXP_BITS'($urandom));
                    sent++;
                end
                1, 2, 3, 4: begin
                    int n;
                    n = $urandom_range(MAX_TERMS);
                    if (n == 0) n = 1;
                    load_poly($urandom_range(1) ? REQ_LOAD_A : REQ_LOAD_B, n,
                              $urandom_range(3) == 0);
                    sent += n;
                end
                default: begin
                    send_request($urandom_range(1) ? REQ_MUL : REQ_ADD,
                                 1'($urandom_range(1)), COEF_BITS'($urandom),
                                 EXP_BITS'($urandom));
                    sent++;
                end
            endcase
        end
        steady = 0;
    endtask

    initial begin
        aresetn = 0;
        s_valid = 0;
        s_req_type = REQ_LOAD_A;
        s_first_term = 0;
        s_coef_in = 0;
        s_exp_in = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);
        test_empty();
        test_extremes();
        test_cancel_and_order();
        test_full();
        test_random(210);
        drain_results();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
hdl/spam_pkg.sv
hdl/sparse_polynomial_add_multiply.sv
tb/testbench.sv
